[design/tsni_pkg.sv]
// Shared types and constants for the TLS server-name extractor.
package tsni_pkg;

    // Counter width for positions and lengths
    localparam int LEN_W = 16;
    // Width of an end-of-field sum (position + 1 + 16-bit length)
    localparam int SUM_W = ((LEN_W > 16) ? LEN_W : 16) + 1;

    // Header constants
    localparam logic [7:0]  REC_HANDSHAKE  = 8'h16;
    localparam logic [7:0]  HS_CLIENT_HELLO = 8'h01;
    localparam logic [LEN_W-1:0] MIN_HELLO = LEN_W'(43);
    localparam logic [15:0] EXT_SERVER_NAME = 16'h0000;
    localparam logic [7:0]  NAME_TYPE_HOST = 8'h00;

    // Parser phases, one-hot
    typedef enum logic [12:0] {
        PH_HDR      = 13'b0000000000001,
        PH_SID_LEN  = 13'b0000000000010,
        PH_SID_SKIP = 13'b0000000000100,
        PH_CS_LEN   = 13'b0000000001000,
        PH_CS_SKIP  = 13'b0000000010000,
        PH_CM_LEN   = 13'b0000000100000,
        PH_CM_SKIP  = 13'b0000001000000,
        PH_EXTS_LEN = 13'b0000010000000,
        PH_EXT_HDR  = 13'b0000100000000,
        PH_EXT_SKIP = 13'b0001000000000,
        PH_SNI_HDR  = 13'b0010000000000,
        PH_NAME     = 13'b0100000000000,
        PH_STOP     = 13'b1000000000000
    } phase_t;

    // One accepted payload byte
    typedef struct packed {
        logic [7:0]  data_byte;
        logic        first_byte;
        logic        last_byte;
        logic [15:0] payload_length;
    } item_t;

    // Result of one parser step
    typedef struct packed {
        logic       has_result;
        logic       name_valid;
        logic [7:0] name_byte;
        logic       name_last;
        logic       payload_done;
        logic       sni_found;
    } result_t;

endpackage

[design/tsni_parser.sv]
// ClientHello parser: holds the parse state and steps it once per payload byte.
module tsni_parser
    import tsni_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    step,     // consume item this cycle
    input  item_t   item,
    output result_t result
);

    phase_t           phase_reg, phase_next;
    logic [LEN_W-1:0] pos_reg, pos_next;
    logic [15:0]      acc_reg, acc_next;
    logic [LEN_W-1:0] skip_reg, skip_next;
    logic [LEN_W-1:0] ext_end_reg, ext_end_next;
    logic [LEN_W-1:0] total_reg, total_next;
    logic [LEN_W-1:0] nrem_reg, nrem_next;
    logic [15:0]      etype_reg, etype_next;
    logic             found_reg, found_next;

    logic [7:0]       d;
    logic [SUM_W-1:0] end_sum;

    assign d = item.data_byte;

    // Next state for one byte
    always_comb begin
        // first byte restarts from a clean state
        if (item.first_byte) begin
            phase_next   = PH_HDR;
            pos_next     = '0;
            acc_next     = '0;
            skip_next    = '0;
            ext_end_next = '0;
            total_next   = LEN_W'(item.payload_length);
            nrem_next    = '0;
            etype_next   = '0;
            found_next   = 1'b0;
        end else begin
            phase_next   = phase_reg;
            pos_next     = pos_reg;
            acc_next     = acc_reg;
            skip_next    = skip_reg;
            ext_end_next = ext_end_reg;
            total_next   = total_reg;
            nrem_next    = nrem_reg;
            etype_next   = etype_reg;
            found_next   = found_reg;
        end
        end_sum = '0;
        result  = '0;

        case (phase_next)
            PH_HDR: begin
                if (total_next < MIN_HELLO || pos_next >= total_next ||
                    (pos_next == LEN_W'(0) && d != REC_HANDSHAKE) ||
                    (pos_next == LEN_W'(5) && d != HS_CLIENT_HELLO)) begin
                    phase_next = PH_STOP;
                end else if (pos_next == MIN_HELLO - LEN_W'(1)) begin
                    phase_next = PH_SID_LEN;
                end
            end
            PH_SID_LEN, PH_CM_LEN: begin
                if (pos_next >= total_next) begin
                    phase_next = PH_STOP;
                end else begin
                    skip_next = LEN_W'(d);
                    acc_next  = '0;
                    if (phase_next == PH_SID_LEN) begin
                        phase_next = (d != 8'd0) ? PH_SID_SKIP : PH_CS_LEN;
                    end else begin
                        phase_next = (d != 8'd0) ? PH_CM_SKIP : PH_EXTS_LEN;
                    end
                end
            end
            PH_CS_LEN, PH_EXTS_LEN: begin
                if (pos_next >= total_next) begin
                    phase_next = PH_STOP;
                end else begin
                    acc_next  = {acc_next[7:0], d};
                    skip_next = skip_next + LEN_W'(1);
                    if (skip_next >= LEN_W'(2)) begin
                        if (phase_next == PH_CS_LEN) begin
                            skip_next  = LEN_W'(acc_next);
                            phase_next = (skip_next != '0) ? PH_CS_SKIP : PH_CM_LEN;
                            acc_next   = '0;
                        end else begin
                            end_sum = SUM_W'(pos_next) + SUM_W'(1) + SUM_W'(acc_next);
                            ext_end_next = (end_sum < SUM_W'(total_next)) ?
                                           LEN_W'(end_sum) : total_next;
                            skip_next  = '0;
                            acc_next   = '0;
                            phase_next = PH_EXT_HDR;
                        end
                    end
                end
            end
            PH_SID_SKIP, PH_CS_SKIP, PH_CM_SKIP, PH_EXT_SKIP: begin
                skip_next = skip_next - LEN_W'(1);
                if (skip_next == '0) begin
                    case (phase_next)
                        PH_SID_SKIP: phase_next = PH_CS_LEN;
                        PH_CS_SKIP:  phase_next = PH_CM_LEN;
                        PH_CM_SKIP:  phase_next = PH_EXTS_LEN;
                        default:     phase_next = PH_EXT_HDR;
                    endcase
                end
            end
            PH_EXT_HDR: begin
                if (pos_next >= ext_end_next) begin
                    phase_next = PH_STOP;
                end else begin
                    if (skip_next < LEN_W'(2)) begin
                        etype_next = {etype_next[7:0], d};
                    end else begin
                        acc_next = {acc_next[7:0], d};
                    end
                    skip_next = skip_next + LEN_W'(1);
                    if (skip_next >= LEN_W'(4)) begin
                        if (etype_next == EXT_SERVER_NAME) begin
                            skip_next  = '0;
                            acc_next   = '0;
                            phase_next = PH_SNI_HDR;
                        end else begin
                            skip_next  = LEN_W'(acc_next);
                            phase_next = (skip_next != '0) ? PH_EXT_SKIP : PH_EXT_HDR;
                            acc_next   = '0;
                        end
                    end
                end
            end
            PH_SNI_HDR: begin
                if (pos_next >= ext_end_next ||
                    (skip_next == LEN_W'(2) && d != NAME_TYPE_HOST)) begin
                    phase_next = PH_STOP;
                end else begin
                    if (skip_next >= LEN_W'(3)) begin
                        acc_next = {acc_next[7:0], d};
                    end
                    skip_next = skip_next + LEN_W'(1);
                    if (skip_next >= LEN_W'(5)) begin
                        end_sum = SUM_W'(pos_next) + SUM_W'(1) + SUM_W'(acc_next);
                        if (acc_next == 16'd0 || end_sum > SUM_W'(ext_end_next)) begin
                            phase_next = PH_STOP;
                        end else begin
                            nrem_next  = LEN_W'(acc_next);
                            skip_next  = '0;
                            phase_next = PH_NAME;
                        end
                    end
                end
            end
            PH_NAME: begin
                result.name_valid = 1'b1;
                result.name_byte  = d;
                nrem_next = nrem_next - LEN_W'(1);
                if (nrem_next == '0) begin
                    result.name_last = 1'b1;
                    found_next = 1'b1;
                    phase_next = PH_STOP;
                end
            end
            default: begin
                phase_next = PH_STOP;
            end
        endcase

        // saturating position
        if (pos_next != '1) begin
            pos_next = pos_next + LEN_W'(1);
        end

        // last byte closes the payload and clears everything
        if (item.last_byte) begin
            result.payload_done = 1'b1;
            result.sni_found    = found_next;
            phase_next   = PH_HDR;
            pos_next     = '0;
            acc_next     = '0;
            skip_next    = '0;
            ext_end_next = '0;
            total_next   = '0;
            nrem_next    = '0;
            etype_next   = '0;
            found_next   = 1'b0;
        end

        result.has_result = result.name_valid | result.payload_done;
    end

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_HDR;
            pos_reg     <= '0;
            acc_reg     <= '0;
            skip_reg    <= '0;
            ext_end_reg <= '0;
            total_reg   <= '0;
            nrem_reg    <= '0;
            etype_reg   <= '0;
            found_reg   <= 1'b0;
        end else if (step) begin
            phase_reg   <= phase_next;
            pos_reg     <= pos_next;
            acc_reg     <= acc_next;
            skip_reg    <= skip_next;
            ext_end_reg <= ext_end_next;
            total_reg   <= total_next;
            nrem_reg    <= nrem_next;
            etype_reg   <= etype_next;
            found_reg   <= found_next;
        end
    end

endmodule

[design/tls_sni_hostname_extractor_top.sv]
// Top level of the TLS server-name extractor: input stage, parser, result stage.
//
//  channel | dir | tdata                         | tuser          | tlast
//  s_      | in  | data_byte, payload_length     | first_byte     | last_byte
//  m_      | out | name_byte                     | flags (below)  | payload_done
//
// One payload byte per cycle while the m_ side takes results; a byte is held in the input
// register, and its result passes through the parser logic into the result register.
// The parser state update is a single pass of compare/add logic per byte.
// aresetn is synchronous, active low; it clears the parse state and both stages.
// A stalled m_ side holds the result; bytes that make no result still drain.
module tls_sni_hostname_extractor_top
    import tsni_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [7:0] data_byte, [23:8] payload_length
    input  logic        s_tuser,   // [0] first_byte
    input  logic        s_tlast,   // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] name_byte
    output logic [2:0]  m_tuser,   // [0] name_valid, [1] name_last, [2] sni_found
    output logic        m_tlast    // payload_done
);

    logic    in_valid_reg;
    item_t   in_item_reg;
    logic    out_valid_reg;
    result_t out_reg;
    result_t res;
    logic    advance;
    logic    s_fire;

    // Input stage moves on when the result slot is free or being taken, or no result is made
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready || !res.has_result);
    assign s_tready = !in_valid_reg || advance;
    assign s_fire   = s_tvalid && s_tready;

    tsni_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .item    (in_item_reg),
        .result  (res)
    );

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_item_reg.data_byte      <= s_tdata[7:0];
            in_item_reg.payload_length <= s_tdata[23:8];
            in_item_reg.first_byte     <= s_tuser;
            in_item_reg.last_byte      <= s_tlast;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && res.has_result) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && res.has_result) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg.name_byte;
    assign m_tuser  = {out_reg.sni_found, out_reg.name_last, out_reg.name_valid};
    assign m_tlast  = out_reg.payload_done;

endmodule

[sim/tls_sni_hostname_extractor_top_tb.sv]
// Self-checking testbench for the TLS ClientHello server-name extractor.
`timescale 1ns / 100ps

module tls_sni_hostname_extractor_top_tb
    import tsni_pkg::*;
();

    // One expected transfer on the m_ side
    typedef struct packed {
        logic       name_valid;
        logic [7:0] name_byte;
        logic       name_last;
        logic       payload_done;
        logic       sni_found;
    } sni_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    tls_sni_hostname_extractor_top u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // Stimulus and scoreboard storage
    item_t       byte_feed[$];
    sni_result_t result_q[$];
    logic [7:0]  frame[$];
    item_t       cur_item;
    bit          in_taken = 1'b0;
    int          send_idle_pct = 0;
    int          stall_pct = 0;
    int          items_queued = 0;
    int          items_accepted = 0;
    int          payloads_framed = 0;
    int          name_bytes_seen = 0;
    int          verdicts_seen = 0;
    int          names_found = 0;
    int          mismatches = 0;

    // Parser shadow state
    phase_t           ph;
    logic [LEN_W-1:0] pos, skip_cnt, ext_end, total, name_left;
    logic [15:0]      acc;
    logic [15:0]      ext_kind;
    logic             found;

    initial begin
        forever #4 aclk = ~aclk;
    end

    task automatic report_mismatch(string msg);
        if (mismatches < 40)
            $display("[%0t] ERROR: %s", $realtime, msg);
        mismatches++;
    endtask

    // ---------------------------------------------------------------------
    // Parser prediction
    // ---------------------------------------------------------------------
    function automatic void parser_clear();
        pos = '0;
        ph = PH_HDR;
        acc = '0;
        skip_cnt = '0;
        ext_end = '0;
        total = '0;
        name_left = '0;
        ext_kind = '0;
        found = 1'b0;
    endfunction

    function automatic logic [15:0] shift_in(logic [15:0] v, logic [7:0] d);
        return {v[7:0], d};
    endfunction

    function automatic void start_skip(logic [LEN_W-1:0] n, phase_t skip_ph, phase_t next_ph);
        skip_cnt = n;
        acc = '0;
        ph = (n != '0) ? skip_ph : next_ph;
    endfunction

    function automatic void parse_byte(logic [7:0] d, logic first, logic last,
                                       logic [15:0] plen);
        sni_result_t      r;
        logic [LEN_W-1:0] p;
        logic [SUM_W-1:0] e;
        r = '0;
        if (first) begin
            parser_clear();
            total = LEN_W'(plen);
        end
        p = pos;
        case (ph)
            PH_HDR: begin
                if (total < MIN_HELLO || p >= total ||
                    (p == 0 && d != REC_HANDSHAKE) || (p == 5 && d != HS_CLIENT_HELLO))
                    ph = PH_STOP;
                else if (p == MIN_HELLO - 1)
                    ph = PH_SID_LEN;
            end
            PH_SID_LEN, PH_CM_LEN: begin
                if (p >= total)
                    ph = PH_STOP;
                else if (ph == PH_SID_LEN)
                    start_skip(LEN_W'(d), PH_SID_SKIP, PH_CS_LEN);
                else
                    start_skip(LEN_W'(d), PH_CM_SKIP, PH_EXTS_LEN);
            end
            PH_CS_LEN, PH_EXTS_LEN: begin
                if (p >= total) begin
                    ph = PH_STOP;
                end else begin
                    acc = shift_in(acc, d);
                    skip_cnt++;
                    if (skip_cnt >= 2) begin
                        if (ph == PH_CS_LEN) begin
                            start_skip(LEN_W'(acc), PH_CS_SKIP, PH_CM_LEN);
                        end else begin
                            // extensions end is capped by the payload end
                            e = SUM_W'(p) + 1'b1 + SUM_W'(acc);
                            ext_end = (e < SUM_W'(total)) ? LEN_W'(e) : total;
                            skip_cnt = '0;
                            acc = '0;
                            ph = PH_EXT_HDR;
                        end
                    end
                end
            end
            PH_SID_SKIP, PH_CS_SKIP, PH_CM_SKIP, PH_EXT_SKIP: begin
                skip_cnt = skip_cnt - 1'b1;
                if (skip_cnt == '0) begin
                    case (ph)
                        PH_SID_SKIP: ph = PH_CS_LEN;
                        PH_CS_SKIP:  ph = PH_CM_LEN;
                        PH_CM_SKIP:  ph = PH_EXTS_LEN;
                        default:     ph = PH_EXT_HDR;
                    endcase
                end
            end
            PH_EXT_HDR: begin
                if (p >= ext_end) begin
                    ph = PH_STOP;
                end else begin
                    // type in the first two bytes, length in the next two
                    if (skip_cnt < 2)
                        ext_kind = {ext_kind[7:0], d};
                    else
                        acc = shift_in(acc, d);
                    skip_cnt++;
                    if (skip_cnt >= 4) begin
                        if (ext_kind == EXT_SERVER_NAME) begin
                            skip_cnt = '0;
                            acc = '0;
                            ph = PH_SNI_HDR;
                        end else begin
                            start_skip(LEN_W'(acc), PH_EXT_SKIP, PH_EXT_HDR);
                        end
                    end
                end
            end
            PH_SNI_HDR: begin
                // list length (ignored), name type, name length
                if (p >= ext_end || (skip_cnt == 2 && d != NAME_TYPE_HOST)) begin
                    ph = PH_STOP;
                end else begin
                    if (skip_cnt >= 3)
                        acc = shift_in(acc, d);
                    skip_cnt++;
                    if (skip_cnt >= 5) begin
                        e = SUM_W'(p) + 1'b1 + SUM_W'(acc);
                        if (acc == '0 || e > SUM_W'(ext_end)) begin
                            ph = PH_STOP;
                        end else begin
                            name_left = LEN_W'(acc);
                            skip_cnt = '0;
                            ph = PH_NAME;
                        end
                    end
                end
            end
            PH_NAME: begin
                r.name_valid = 1'b1;
                r.name_byte = d;
                name_left = name_left - 1'b1;
                if (name_left == '0) begin
                    r.name_last = 1'b1;
                    found = 1'b1;
                    ph = PH_STOP;
                end
            end
            default: ph = PH_STOP;
        endcase

        if (pos != '1)
            pos++;

        if (last) begin
            r.payload_done = 1'b1;
            r.sni_found = found;
            parser_clear();
        end

        if (r.name_valid || r.payload_done)
            result_q.insert(result_q.size(), r);
    endfunction

    // ---------------------------------------------------------------------
    // Payload construction
    // ---------------------------------------------------------------------
    function automatic void queue_item(logic [7:0] d, logic first, logic last,
                                       logic [15:0] plen);
        item_t it;
        it.data_byte = d;
        it.first_byte = first;
        it.last_byte = last;
        it.payload_length = plen;
        byte_feed.insert(byte_feed.size(), it);
        items_queued++;
    endfunction

    function automatic void put16(int v);
        frame.insert(frame.size(), 8'(v >> 8));
        frame.insert(frame.size(), 8'(v));
    endfunction

    function automatic void put_rand(int n);
        repeat (n) frame.insert(frame.size(), 8'($urandom));
    endfunction

    function automatic void put_other_ext();
        int len;
        len = $urandom_range(0, 4);
        put16($urandom_range(1, 65535));
        put16(len);
        put_rand(len);
    endfunction

    // ClientHello with a random prefix of extensions, an optional SNI entry
    function automatic void build_hello(int nlen, int decl, logic [7:0] ntype,
                                        int slack, bit with_sni);
        int sid, cs, cm, len_idx, ext_total;
        frame.delete();
        frame.insert(frame.size(), REC_HANDSHAKE);
        put_rand(4);
        frame.insert(frame.size(), HS_CLIENT_HELLO);
        put_rand(37);
        sid = ($urandom_range(0, 7) == 0) ? 32 : $urandom_range(0, 4);
        frame.insert(frame.size(), 8'(sid));
        put_rand(sid);
        cs = 2 * $urandom_range(0, 3);
        put16(cs);
        put_rand(cs);
        cm = $urandom_range(0, 2);
        frame.insert(frame.size(), 8'(cm));
        put_rand(cm);
        len_idx = frame.size();
        put16(0);
        repeat ($urandom_range(0, 2)) put_other_ext();
        if (with_sni) begin
            put16(EXT_SERVER_NAME);
            put16(decl + 5);
            put16(decl + 3);
            frame.insert(frame.size(), ntype);
            put16(decl);
            put_rand(nlen);
        end
        if ($urandom_range(0, 3) == 0)
            put_other_ext();
        // patch the extensions length, possibly off by a slack
        ext_total = frame.size() - len_idx - 2 + slack;
        if (ext_total < 0)
            ext_total = 0;
        frame[len_idx] = 8'(ext_total >> 8);
        frame[len_idx + 1] = 8'(ext_total);
    endfunction

    function automatic void push_frame(int stated, int stop_at, bit with_last);
        for (int i = 0; i <= stop_at; i++)
            queue_item(frame[i], i == 0, with_last && i == stop_at,
                       (i == 0) ? 16'(stated) : 16'($urandom));
        payloads_framed++;
    endfunction

    // One random payload: mostly well formed, the rest broken or noise
    function automatic void gen_payload();
        int kind, nlen, decl, slack, stated, stop_at, n;
        logic [7:0] ntype;
        bit with_sni, with_last, corrupt;
        kind = $urandom_range(0, 99);
        nlen = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 16);
        decl = nlen;
        ntype = NAME_TYPE_HOST;
        slack = 0;
        with_sni = 1'b1;
        corrupt = 1'b0;
        if (kind >= 60 && kind < 80) begin
            case ($urandom_range(0, 5))
                0: ntype = 8'($urandom_range(1, 255));
                1: begin
                    nlen = 0;
                    decl = 0;
                end
                2: decl = nlen + $urandom_range(1, 20);
                3: slack = $urandom_range(0, 1) ? -$urandom_range(1, 20) : $urandom_range(1, 20);
                4: with_sni = 1'b0;
                default: corrupt = 1'b1;
            endcase
        end
        build_hello(nlen, decl, ntype, slack, with_sni);
        if (corrupt)
            frame[$urandom_range(0, frame.size() - 1)] = 8'($urandom);
        stated = frame.size();
        stop_at = frame.size() - 1;
        with_last = 1'b1;
        if (kind >= 80 && kind < 88) begin
            stated += $urandom_range(1, 30);
        end else if (kind >= 88 && kind < 93) begin
            stated -= $urandom_range(1, 20);
        end else if (kind >= 93 && kind < 97) begin
            stop_at = $urandom_range(0, frame.size() - 1);
        end else if (kind >= 97) begin
            // left open: the next first mark restarts the parser
            stop_at = $urandom_range(0, frame.size() - 1);
            with_last = 1'b0;
        end
        push_frame(stated, stop_at, with_last);
        // stray bytes with no first mark
        if ($urandom_range(0, 9) == 0) begin
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++)
                queue_item(8'($urandom), 1'b0, i == n - 1, 16'($urandom));
        end
    endfunction

    task automatic wait_drained();
        int n;
        n = 0;
        while ((items_accepted != items_queued || result_q.size() != 0) && n < 50000) begin
            @(negedge aclk);
            n++;
        end
    endtask

    // ---------------------------------------------------------------------
    // Driver: inputs change on the falling edge
    // ---------------------------------------------------------------------
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || in_taken) begin
            if (byte_feed.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                cur_item = byte_feed.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= {cur_item.payload_length, cur_item.data_byte};
                s_tuser <= cur_item.first_byte;
                s_tlast <= cur_item.last_byte;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
        m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // ---------------------------------------------------------------------
    // Monitor: both channels sampled on the rising edge
    // ---------------------------------------------------------------------
    always @(posedge aclk) begin
        sni_result_t exp_r;
        in_taken = aresetn && s_tvalid && s_tready;
        if (aresetn && m_tvalid && m_tready) begin
            if (result_q.size() == 0) begin
                report_mismatch($sformatf("unexpected transfer: data %02h user %03b last %b",
                                          m_tdata, m_tuser, m_tlast));
            end else begin
                exp_r = result_q.pop_front();
                if (m_tuser[0] !== exp_r.name_valid || m_tdata !== exp_r.name_byte ||
                    m_tuser[1] !== exp_r.name_last || m_tlast !== exp_r.payload_done ||
                    m_tuser[2] !== exp_r.sni_found)
                    report_mismatch($sformatf(
                        "got valid %b byte %02h nlast %b done %b found %b, want %b %02h %b %b %b",
                        m_tuser[0], m_tdata, m_tuser[1], m_tlast, m_tuser[2],
                        exp_r.name_valid, exp_r.name_byte, exp_r.name_last,
                        exp_r.payload_done, exp_r.sni_found));
                if (exp_r.name_valid)
                    name_bytes_seen++;
                if (exp_r.payload_done)
                    verdicts_seen++;
                if (exp_r.payload_done && exp_r.sni_found)
                    names_found++;
            end
        end
        if (in_taken) begin
            parse_byte(s_tdata[7:0], s_tuser, s_tlast, s_tdata[23:8]);
            items_accepted++;
        end
    end

    // ---------------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------------
    initial begin
        int send_pct[4];
        int recv_pct[4];
        parser_clear();
        send_pct = '{0, 49, 0, 19};
        recv_pct = '{0, 0, 49, 19};
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed: field extremes and short or malformed payloads
        queue_item(8'h00, 1'b1, 1'b1, 16'h0000);
        queue_item(8'hFF, 1'b1, 1'b1, 16'hFFFF);
        queue_item(REC_HANDSHAKE, 1'b0, 1'b0, 16'h5555);
        queue_item(HS_CLIENT_HELLO, 1'b0, 1'b0, 16'hAAAA);
        queue_item(8'hAA, 1'b0, 1'b1, 16'h0000);
        queue_item(REC_HANDSHAKE, 1'b1, 1'b0, 16'd43);
        queue_item(8'h03, 1'b0, 1'b1, 16'h0000);
        queue_item(8'h17, 1'b1, 1'b0, 16'd100);
        queue_item(8'h03, 1'b0, 1'b1, 16'h0000);
        queue_item(REC_HANDSHAKE, 1'b1, 1'b0, 16'd42);
        queue_item(8'h03, 1'b0, 1'b0, 16'h0000);
        queue_item(8'h01, 1'b0, 1'b1, 16'h0000);
        queue_item(REC_HANDSHAKE, 1'b1, 1'b0, 16'd60);
        queue_item(8'h55, 1'b1, 1'b1, 16'd1);

        // Random payloads over four idling profiles, draining between them
        for (int k = 0; k < 4; k++) begin
            send_idle_pct = send_pct[k];
            stall_pct = recv_pct[k];
            while (items_queued < 275 * (k + 1))
                gen_payload();
            wait_drained();
        end

        repeat (8) @(negedge aclk);
        if (result_q.size() != 0)
            report_mismatch($sformatf("%0d expected transfers never arrived", result_q.size()));
        if (items_accepted != items_queued)
            report_mismatch($sformatf("only %0d of %0d input transfers accepted",
                                      items_accepted, items_queued));
        $display("Sent %0d payload bytes in %0d framed payloads plus stray bytes.",
                 items_accepted, payloads_framed);
        $display("Checked %0d host name bytes and %0d verdicts (%0d with a name), %0d errors.",
                 name_bytes_seen, verdicts_seen, names_found, mismatches);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Run limit
    initial begin
        #4_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
